// File: src/assert_macros.svh
// Assertion macros shared by the checker module of the frame splitter.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/mes_pkg.sv
// Package of the MPEG-2 elementary stream frame splitter: widths, start code
// bytes, frame kind codes and beat payload types. No dependencies.
package mes_pkg;

    localparam int unsigned BYTE_W               = 8;
    localparam int unsigned LEN_W                = 21;
    localparam int unsigned KIND_W               = 2;
    localparam int unsigned WIN_LEN              = 6;
    localparam int unsigned DEF_MAX_PACKET_BYTES = 1048576;

    // Start code bytes.
    localparam logic [BYTE_W-1:0] PREFIX_ZERO  = 8'h00;
    localparam logic [BYTE_W-1:0] PREFIX_ONE   = 8'h01;
    localparam logic [BYTE_W-1:0] SEQ_HDR_CODE = 8'hB3;
    localparam logic [BYTE_W-1:0] PICTURE_CODE = 8'h00;

    // Picture coding types.
    localparam logic [2:0] PTYPE_P = 3'd2;
    localparam logic [2:0] PTYPE_B = 3'd3;

    // Frame kind codes on the result beat.
    localparam logic [KIND_W-1:0] KIND_SEQ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_P     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_B     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
    } t_in_beat;

    typedef struct packed {
        logic [LEN_W-1:0]  packet_length;
        logic [KIND_W-1:0] frame_kind;
        logic              overflow;
    } t_out_beat;

endpackage

// File: src/mes_stream_if.sv
// Valid/ready stream interface used for the byte input and the result output.
// The payload type is a parameter; the beat types live in mes_pkg.
interface mes_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/mpeg2_es_frame_splitter.sv
// MPEG-2 elementary stream frame splitter: one byte per beat in, one packet
// result beat out per completed or overflowed packet. Uses mes_pkg, mes_stream_if.
//
// A result appears on the output in the cycle after the byte that ends the
// packet is accepted. One byte is taken per clock, but the input stalls while
// a result is held and not taken.
// Reset (i_rst_n low, synchronous): the block searches for sync again, the
// window and byte count are cleared and any result not yet taken is dropped.
module mpeg2_es_frame_splitter #(
    parameter int unsigned MAX_PACKET_BYTES = mes_pkg::DEF_MAX_PACKET_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mes_stream_if.sink    i_in,
    mes_stream_if.source  o_out
);
    import mes_pkg::*;

    // The incremented count reaches MAX_PACKET_BYTES + 6 inside a packet.
    localparam int unsigned CNT_W  = $clog2(MAX_PACKET_BYTES + WIN_LEN + 1);
    localparam int unsigned WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    // A packet overflows once it holds more than MAX_PACKET_BYTES bytes up to
    // the oldest window byte, i.e. the count passes MAX_PACKET_BYTES + 5.
    localparam logic [CNT_W-1:0] OVF_LIMIT = CNT_W'(MAX_PACKET_BYTES + WIN_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_WIN   = CNT_W'(WIN_LEN);
    localparam logic [LEN_W-1:0] OVF_LEN   = LEN_W'(MAX_PACKET_BYTES);

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_SEQ    = 2'd1,
        MODE_PIC    = 2'd2
    } t_mode;

    // State registers.
    t_mode             r_mode, n_mode;
    logic [BYTE_W-1:0] r_win [WIN_LEN-1];
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_is_b, n_is_b;     // held picture is a B picture
    logic              r_out_valid;
    t_out_beat         r_out, n_out;

    logic              accept;
    logic              emit;
    logic              prefix, seq_code, pb_code;
    logic [2:0]        ptype;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  search_cnt;
    logic [CNT_W-1:0]  len_diff;
    logic [WIDE_W-1:0] len_wide;
    logic [KIND_W-1:0] cur_kind;
    logic              ends;

    // The input side stalls only in reset or when a result is held and not being taken.
    assign i_in.ready    = i_rst_n && (!r_out_valid || o_out.ready);
    assign accept        = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Start codes are judged at the oldest window byte; the incoming byte is
    // the sixth, whose bits 5:3 carry the picture coding type.
    assign prefix   = (r_win[0] == PREFIX_ZERO) && (r_win[1] == PREFIX_ZERO)
                   && (r_win[2] == PREFIX_ONE);
    assign seq_code = prefix && (r_win[3] == SEQ_HDR_CODE);
    assign ptype    = i_in.payload.stream_byte[5:3];
    assign pb_code  = prefix && (r_win[3] == PICTURE_CODE)
                   && ((ptype == PTYPE_P) || (ptype == PTYPE_B));

    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign len_diff = cnt_inc - CNT_WIN;
    assign len_wide = WIDE_W'(len_diff);

    always_comb begin
        n_mode     = r_mode;
        n_cnt      = r_cnt;
        n_is_b     = r_is_b;
        emit       = 1'b0;
        n_out      = r_out;
        cur_kind   = (r_mode == MODE_SEQ) ? KIND_SEQ : (r_is_b ? KIND_B : KIND_P);
        ends       = pb_code || ((r_mode == MODE_PIC) && seq_code);
        search_cnt = (r_cnt < CNT_WIN) ? cnt_inc : r_cnt;

        case (r_mode)
            MODE_SEQ, MODE_PIC: begin
                n_cnt = cnt_inc;
                if (ends) begin
                    // The code that closes this packet opens the next one.
                    emit                = 1'b1;
                    n_out.packet_length = len_wide[LEN_W-1:0];
                    n_out.frame_kind    = cur_kind;
                    n_out.overflow      = 1'b0;
                    n_cnt               = CNT_WIN;
                    if (seq_code) begin
                        n_mode = MODE_SEQ;
                    end else begin
                        n_mode = MODE_PIC;
                        n_is_b = (ptype == PTYPE_B);
                    end
                end else if (cnt_inc > OVF_LIMIT) begin
                    // Packet outgrew the buffer: report it and hunt for sync.
                    emit                = 1'b1;
                    n_out.packet_length = OVF_LEN;
                    n_out.frame_kind    = cur_kind;
                    n_out.overflow      = 1'b1;
                    n_mode              = MODE_SEARCH;
                    n_cnt               = CNT_WIN;
                end
            end
            default: begin
                // While searching the count only tracks how full the window
                // is, so the zeros left by reset never look like a code.
                n_mode = MODE_SEARCH;
                n_cnt  = search_cnt;
                if ((search_cnt >= CNT_WIN) && seq_code) begin
                    n_mode = MODE_SEQ;
                    n_cnt  = CNT_WIN;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SEARCH;
            r_cnt       <= '0;
            r_is_b      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_is_b <= n_is_b;
                for (int i = 0; i < WIN_LEN - 2; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WIN_LEN-2] <= i_in.payload.stream_byte;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: src/mes_checker.sv
// Port-level checker for the frame splitter, attached by bind.
// Uses assert_macros.svh and mes_pkg.
`include "assert_macros.svh"

module mes_checker #(
    parameter int unsigned MAX_PACKET_BYTES = mes_pkg::DEF_MAX_PACKET_BYTES
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [mes_pkg::LEN_W-1:0]   i_out_length,
    input logic [mes_pkg::KIND_W-1:0]  i_out_kind,
    input logic                        i_out_overflow
);
    import mes_pkg::*;

    localparam logic [LEN_W-1:0] OVF_LEN = LEN_W'(MAX_PACKET_BYTES);

    logic out_stall;
    assign out_stall = i_out_valid && !i_out_ready;

    // A held result stays offered.
    `ASSERT_HOLDS(a_out_valid_held, i_clk, i_rst_n, out_stall |=> i_out_valid, "result dropped while stalled")

    // A fresh result only follows an accepted byte.
    `ASSERT_HOLDS(a_result_has_cause, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready), "result without an accepted byte")

    // An overflow result always reports the buffer size.
    `ASSERT_HOLDS(a_ovf_length, i_clk, i_rst_n, (i_out_valid && i_out_overflow) |-> (i_out_length == OVF_LEN), "overflow length is not the buffer size")

    // The unused kind code is never reported.
    `ASSERT_NEVER(a_kind_legal, i_clk, i_rst_n, i_out_valid && (i_out_kind == KIND_UNUSED), "illegal frame kind")

endmodule

bind mpeg2_es_frame_splitter mes_checker #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
) u_mes_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_length   (o_out.payload.packet_length),
    .i_out_kind     (o_out.payload.frame_kind),
    .i_out_overflow (o_out.payload.overflow)
);
